// ===== sv/irpw_pkg.sv =====
// Shared types and constants for the IR pulse-width capture block.
`timescale 1ns / 1ps

package irpw_pkg;

  localparam int unsigned TIME_W     = 40;
  localparam int unsigned DUR_W      = 32;
  localparam int unsigned GAP_W      = 24;
  localparam int unsigned MINP_W     = 10;
  localparam int unsigned IDX_W      = 10;
  localparam int unsigned COUNT_W    = 11;
  localparam int unsigned ENTRY_W    = DUR_W + 1;
  localparam int unsigned IN_DATA_W  = 56;
  localparam int unsigned OUT_DATA_W = 48;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = GAP_W;

  localparam logic [GAP_W-1:0]  GAP_RESET  = 24'd80000;
  localparam logic [MINP_W-1:0] MINP_RESET = 10'd10;

  // Result beat layout, lowest bit first
  localparam int unsigned OUT_READY_LSB = 0;
  localparam int unsigned OUT_COUNT_LSB = 1;
  localparam int unsigned OUT_VALID_LSB = OUT_COUNT_LSB + COUNT_W;
  localparam int unsigned OUT_LEVEL_LSB = OUT_VALID_LSB + 1;
  localparam int unsigned OUT_DUR_LSB   = OUT_LEVEL_LSB + 1;

  typedef enum logic [1:0] {
    KIND_EDGE    = 2'd0,
    KIND_POLL    = 2'd1,
    KIND_READ    = 2'd2,
    KIND_RELEASE = 2'd3
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAP_LIMIT  = 1'b0,
    REG_MIN_PULSES = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic             level;
    logic [DUR_W-1:0] duration;
  } pulse_t;

endpackage

// ===== sv/irpw_pulse_mem.sv =====
// Pulse store: one write port, one registered read port.
`timescale 1ns / 1ps

module irpw_pulse_mem
  import irpw_pkg::*;
#(
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  pulse_t            wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output pulse_t            rdata_o
);

  pulse_t mem_q [DEPTH];
  pulse_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // hold read data while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/ir_pulse_width_capture.sv =====
// Top level of the IR pulse-width capture block.
`timescale 1ns / 1ps

// Records an IR line as (level, duration) pulses framed by idle gaps. Each input
// beat carries a kind on tuser: edge, timeout poll, read of a stored pulse, or
// release. Edges store the level held before the edge and the microseconds since
// the previous edge (negative time reads as 0, durations saturate at 32 bits). An
// idle time above gap_limit_us either marks the frame ready, when it holds more
// than min_frame_pulses pulses, or drops the short run as noise; a full store also
// marks it ready. Every input beat yields exactly one result beat carrying the
// ready flag, the stored count and, for reads, the addressed pulse. Throughput is
// one beat per clock unless the output stalls; each result appears in the cycle
// after acceptance, with the registered pulse memory read. The result register
// parts the two sides: a new beat is taken whenever the result register is empty
// or is being drained in the same cycle. Write configuration only while idle.
module ir_pulse_width_capture
  import irpw_pkg::*;
#(
  parameter int unsigned MAX_PULSES = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // tdata: now_us[39:0], line_level[40], read_index[50:41], zero fill
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: kind[1:0]
  input  logic [1:0]            s_axis_tuser,
  // result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // tdata: frame_ready[0], pulse_count[11:1], entry_valid[12], entry_level[13],
  //        entry_duration_us[45:14], zero fill
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  localparam int unsigned ADDR_W = $clog2(MAX_PULSES);
  localparam int unsigned CNT_W  = $clog2(MAX_PULSES + 1);
  // common width for comparing the count against 10-bit fields
  localparam int unsigned CMP_W  = (CNT_W > IDX_W) ? CNT_W : IDX_W;
  // width for narrowing or widening the count onto the result field
  localparam int unsigned OUTC_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_PULSES);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_PULSES - 1);

  // Configuration registers
  logic [GAP_W-1:0]  gap_limit_q;
  logic [MINP_W-1:0] min_pulses_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_limit_q  <= GAP_RESET;
      min_pulses_q <= MINP_RESET;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_GAP_LIMIT:  gap_limit_q  <= cfg_data_i;
        REG_MIN_PULSES: min_pulses_q <= cfg_data_i[MINP_W-1:0];
        default: ;
      endcase
    end
  end

  // Input beat fields
  kind_e             kind;
  logic [TIME_W-1:0] now_us;
  logic              line_level;
  logic [IDX_W-1:0]  read_index;

  assign kind       = kind_e'(s_axis_tuser);
  assign now_us     = s_axis_tdata[TIME_W-1:0];
  assign line_level = s_axis_tdata[TIME_W];
  assign read_index = s_axis_tdata[TIME_W+IDX_W:TIME_W+1];

  // Capture state
  logic [CNT_W-1:0]  count_q, count_d;
  logic              ready_q, ready_d;
  logic [TIME_W-1:0] last_time_q, last_time_d;
  logic              last_level_q, last_level_d;

  // Result register
  logic              out_valid_q;
  logic              res_ready_q;
  logic [CNT_W-1:0]  res_count_q;
  logic              res_entry_valid_q;
  logic              res_entry_valid_d;

  logic accept;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Elapsed time since the last edge; a timestamp at or before it reads as 0
  logic [TIME_W-1:0] elapsed;
  logic              gap_hit;
  logic [DUR_W-1:0]  dur_sat;
  logic              over_min;

  assign elapsed  = (now_us > last_time_q) ? (now_us - last_time_q) : '0;
  assign gap_hit  = elapsed > TIME_W'(gap_limit_q);
  assign dur_sat  = (|elapsed[TIME_W-1:DUR_W]) ? '1 : elapsed[DUR_W-1:0];
  assign over_min = CMP_W'(count_q) > CMP_W'(min_pulses_q);

  // Memory access controls
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  pulse_t            mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  pulse_t            mem_rdata;

  logic [CNT_W-1:0] gap_count;
  logic             gap_ready;

  always_comb begin
    count_d           = count_q;
    ready_d           = ready_q;
    last_time_d       = last_time_q;
    last_level_d      = last_level_q;
    res_entry_valid_d = 1'b0;
    mem_we            = 1'b0;
    mem_re            = 1'b0;
    mem_waddr         = '0;
    mem_raddr         = CMP_W'(read_index) < CMP_W'(count_q) ?
                        ADDR_W'(CMP_W'(read_index)) : '0;
    mem_wdata         = '{level: last_level_q, duration: dur_sat};

    // Gap decision ahead of storing the edge: accept the frame or drop the run
    gap_count = count_q;
    gap_ready = ready_q;
    if (gap_hit) begin
      if (over_min) begin
        gap_ready = 1'b1;
      end else begin
        gap_count = '0;
      end
    end
    mem_waddr = gap_count[ADDR_W-1:0];

    if (accept) begin
      case (kind)
        KIND_EDGE: begin
          count_d = gap_count;
          ready_d = gap_ready;
          if (!gap_ready && (gap_count < CNT_MAX)) begin
            mem_we  = 1'b1;
            count_d = gap_count + 1'b1;
            ready_d = (gap_count == CNT_LAST);
          end
          last_time_d  = now_us;
          last_level_d = line_level;
        end
        KIND_POLL: begin
          if (over_min && gap_hit) begin
            ready_d = 1'b1;
          end
        end
        KIND_READ: begin
          res_entry_valid_d = CMP_W'(read_index) < CMP_W'(count_q);
          mem_re            = res_entry_valid_d;
        end
        KIND_RELEASE: begin
          count_d      = '0;
          ready_d      = 1'b0;
          last_time_d  = now_us;
          last_level_d = line_level;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      ready_q      <= 1'b0;
      last_time_q  <= '0;
      last_level_q <= 1'b1;
    end else begin
      count_q      <= count_d;
      ready_q      <= ready_d;
      last_time_q  <= last_time_d;
      last_level_q <= last_level_d;
    end
  end

  // Result beat: capture the post-update state on accept, hold while stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_ready_q       <= ready_d;
      res_count_q       <= count_d;
      res_entry_valid_q <= res_entry_valid_d;
    end
  end

  irpw_pulse_mem #(
    .DEPTH (MAX_PULSES),
    .ADDR_W(ADDR_W)
  ) u_pulse_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // Entry fields read as zero unless this beat returned a valid pulse
  logic [OUTC_W-1:0] count_wide;
  logic              entry_level;
  logic [DUR_W-1:0]  entry_dur;

  assign count_wide  = OUTC_W'(res_count_q);
  assign entry_level = res_entry_valid_q & mem_rdata.level;
  assign entry_dur   = res_entry_valid_q ? mem_rdata.duration : '0;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {
    (OUT_DATA_W - OUT_DUR_LSB - DUR_W)'(0),
    entry_dur,
    entry_level,
    res_entry_valid_q,
    count_wide[COUNT_W-1:0],
    res_ready_q
  };

endmodule

// ===== sv/irpw_checker.sv =====
// Port-level assertions for the IR pulse-width capture block, bound to the top.
`timescale 1ns / 1ps

module irpw_checker
  import irpw_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  logic [COUNT_W-1:0] count;
  logic               entry_valid;
  logic               entry_level;
  logic [DUR_W-1:0]   entry_dur;

  assign count       = m_axis_tdata[OUT_VALID_LSB-1:OUT_COUNT_LSB];
  assign entry_valid = m_axis_tdata[OUT_VALID_LSB];
  assign entry_level = m_axis_tdata[OUT_LEVEL_LSB];
  assign entry_dur   = m_axis_tdata[OUT_DUR_LSB+DUR_W-1:OUT_DUR_LSB];

  // a pending result stays until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat dropped while stalled");

  // an empty result register never blocks the input
  a_in_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty result register");

  // every accepted beat yields a result on the next cycle
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("accepted beat produced no result");

  // entry fields are zero unless a valid pulse was returned
  a_entry_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !entry_valid |-> !entry_level && (entry_dur == '0))
    else $error("entry fields set without a valid entry");

  // a valid entry implies a non-empty store
  a_entry_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && entry_valid |-> (count != '0))
    else $error("valid entry reported with empty store");

endmodule

bind ir_pulse_width_capture irpw_checker u_irpw_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
